[rtl/ptb_pkg.sv]
// Shared types, constants and saturating adders for the palindromic tree builder.
// No dependencies; used by ptb_node_mem and palindromic_tree_builder_core.
`default_nettype none
package ptb_pkg;

   localparam int MAX_LEN_DEF  = 1024;
   localparam int ALPHABET_DEF = 26;

   localparam int CMD_W  = 2;
   localparam int SYM_W  = 5;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 32;
   localparam int SUM_W  = 48;

   localparam logic [CMD_W-1:0] CMD_APPEND   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FINALIZE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_ORDER = 2'd2;

   typedef struct packed {
      logic len;
      logic link;
      logic cnt;
   } node_wr_type;

   function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {{(SUM_W-CNT_W+1){1'b0}}, b};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/palindromic_tree_builder_core.sv]
// Palindromic tree (eertree) builder: append, finalize and query sequencer with text,
// query and edge memories. Depends on ptb_pkg and ptb_node_mem.
//
//   channel | direction | ports
//   req     | in        | req_valid req_ready req_command req_symbol req_restart
//   rsp     | out       | rsp_valid rsp_ready rsp_status rsp_node rsp_is_new
//           |           | rsp_distinct_count rsp_longest rsp_query_sum
//
// One beat at a time, from accept to the rsp register. Each suffix-link step is a node
// read, a text read and a compare, with no compare when the mirror position falls
// before the start or the node is root 0; each edge lookup is a read and a data state.
// An append then bumps a count, or walks and looks up again to create a node. A query
// walks the same loop and adds a count. Finalize makes two passes, per node a read and
// a count update if its link is 2 or more. After reset the edge memory is zeroed with
// req_ready low. A finished beat sits in the rsp register; the next req beat is taken
// while it waits, and that one holds until the register frees.
`default_nettype none
module palindromic_tree_builder_core #(
   parameter int MAX_LEN  = ptb_pkg::MAX_LEN_DEF,
   localparam int ALPHABET = ptb_pkg::ALPHABET_DEF,
   localparam int NODES = MAX_LEN + 2,
   localparam int NW    = $clog2(NODES),
   localparam int AW    = $clog2(MAX_LEN),
   localparam int EDEPTH = NODES * ALPHABET,
   localparam int EAW   = $clog2(EDEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ptb_pkg::CMD_W-1:0]     req_command,
   input  wire logic [ptb_pkg::SYM_W-1:0]     req_symbol,
   input  wire logic                          req_restart,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ptb_pkg::STAT_W-1:0]         rsp_status,
   output logic [NW-1:0]                      rsp_node,
   output logic                               rsp_is_new,
   output logic [NW-1:0]                      rsp_distinct_count,
   output logic [NW-1:0]                      rsp_longest,
   output logic [ptb_pkg::SUM_W-1:0]          rsp_query_sum
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_NRD   = 4'd2;
   localparam logic [3:0] S_NLEN  = 4'd3;
   localparam logic [3:0] S_TCMP  = 4'd4;
   localparam logic [3:0] S_ERD   = 4'd5;
   localparam logic [3:0] S_EDAT  = 4'd6;
   localparam logic [3:0] S_CRD   = 4'd7;
   localparam logic [3:0] S_CUPD  = 4'd8;
   localparam logic [3:0] S_FRD   = 4'd9;
   localparam logic [3:0] S_FA    = 4'd10;
   localparam logic [3:0] S_FB    = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   localparam logic [1:0] M_W1 = 2'd0;
   localparam logic [1:0] M_W2 = 2'd1;
   localparam logic [1:0] M_Q  = 2'd2;

   localparam int CW = ptb_pkg::CNT_W;
   localparam int SW = ptb_pkg::SUM_W;

   logic [4:0] text_mem  [MAX_LEN];
   logic [4:0] query_mem [MAX_LEN];
   logic [NW-1:0] edge_mem [EDEPTH];

   logic [3:0]  state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [ptb_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [ptb_pkg::SYM_W-1:0] sym_ff, sym_in;
   logic [ptb_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic        new_ff, new_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] link_ff, link_in;
   logic signed [NW:0] len_ff, len_in;
   logic signed [NW:0] plen_ff, plen_in;
   logic [EAW-1:0] pedge_ff, pedge_in;
   logic [EAW-1:0] eaddr_ff, eaddr_in;
   logic [NW-1:0] tgt_ff, tgt_in;
   logic [NW-1:0] fi_ff, fi_in;
   logic          fpass_ff, fpass_in;
   logic [CW-1:0] fcnt_ff, fcnt_in;
   logic [NW-1:0] flink_ff, flink_in;
   logic [NW-1:0] last_ff, last_in;
   logic [NW-1:0] ntot_ff, ntot_in;
   logic [NW-1:0] tlen_ff, tlen_in;
   logic [NW-1:0] long_ff, long_in;
   logic [NW-1:0] qnode_ff, qnode_in;
   logic [NW-1:0] qlen_ff, qlen_in;
   logic [SW-1:0] qsum_ff, qsum_in;
   logic          fin_ff, fin_in;
   logic [EAW-1:0] clr_ff, clr_in;
   logic          rv_ff, rv_in;
   logic [ptb_pkg::STAT_W-1:0] rstat_ff, rstat_in;
   logic [NW-1:0] rnode_ff, rnode_in;
   logic          rnew_ff, rnew_in;
   logic [NW-1:0] rdist_ff, rdist_in;
   logic [NW-1:0] rlong_ff, rlong_in;
   logic [SW-1:0] rsum_ff, rsum_in;

   logic          t_we, q_we, e_we;
   logic [AW-1:0] st_waddr, st_raddr;
   logic [4:0]    t_rd, q_rd;
   logic [EAW-1:0] e_waddr;
   logic [NW-1:0] e_wdata, e_rd, e_val;

   logic [NW-1:0] nm_raddr, nm_waddr, nm_wlen, nm_wlink;
   logic [CW-1:0] nm_wcnt, nm_cnt;
   logic signed [NW:0] nm_len;
   logic [NW-1:0] nm_link;
   ptb_pkg::node_wr_type nm_we;

   logic          sym_bad, req_bad, accept, judge, hit;
   logic [NW-1:0] pos, link_cur;
   logic signed [NW:0] len_cur, nlen;
   logic signed [NW+1:0] at;
   logic [EAW-1:0] ea_cur, ea_root;
   logic [4:0]    st_data;

   ptb_node_mem #(.NODES(NODES), .NW(NW)) u_node (
      .clock   (clock),
      .rd_addr (nm_raddr),
      .rd_len  (nm_len),
      .rd_link (nm_link),
      .rd_cnt  (nm_cnt),
      .wr_en   (nm_we),
      .wr_addr (nm_waddr),
      .wr_len  (nm_wlen),
      .wr_link (nm_wlink),
      .wr_cnt  (nm_wcnt)
   );

   always_ff @(posedge clock) begin
      if (t_we) begin
         text_mem[st_waddr] <= sym_in;
      end
      if (q_we) begin
         query_mem[st_waddr] <= sym_in;
      end
      if (e_we) begin
         edge_mem[e_waddr] <= e_wdata;
      end
      t_rd <= text_mem[st_raddr];
      q_rd <= query_mem[st_raddr];
      e_rd <= edge_mem[eaddr_ff];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign req_bad   = int'(req_symbol) >= ALPHABET;
   assign sym_bad   = int'(sym_ff) >= ALPHABET;
   assign ea_cur    = sym_bad ? '0 : EAW'(cur_ff) * EAW'(ALPHABET) + EAW'(sym_ff);
   assign ea_root   = sym_bad ? '0 : EAW'(sym_ff);
   assign e_val     = sym_bad ? '0 : e_rd;
   assign pos       = (mode_ff == M_Q) ? qlen_ff : tlen_ff;
   assign len_cur   = (state_ff == S_NLEN) ? nm_len : len_ff;
   assign link_cur  = (state_ff == S_NLEN) ? nm_link : link_ff;
   assign at        = $signed({2'b00, pos}) - $signed({len_cur[NW], len_cur})
                      - (NW+2)'(1);
   assign st_data   = (mode_ff == M_Q) ? q_rd : t_rd;
   assign nlen      = plen_ff + (NW+1)'(2);

   always_comb begin
      state_in = state_ff;  mode_in = mode_ff;  cmd_in = cmd_ff;  sym_in = sym_ff;
      stat_in = stat_ff;  new_in = new_ff;  cur_in = cur_ff;  link_in = link_ff;
      len_in = len_ff;  plen_in = plen_ff;  pedge_in = pedge_ff;  eaddr_in = eaddr_ff;
      tgt_in = tgt_ff;  fi_in = fi_ff;  fpass_in = fpass_ff;  fcnt_in = fcnt_ff;
      flink_in = flink_ff;  last_in = last_ff;  ntot_in = ntot_ff;  tlen_in = tlen_ff;
      long_in = long_ff;  qnode_in = qnode_ff;  qlen_in = qlen_ff;  qsum_in = qsum_ff;
      fin_in = fin_ff;  clr_in = clr_ff;
      rv_in = rv_ff && !rsp_ready;
      rstat_in = rstat_ff;  rnode_in = rnode_ff;  rnew_in = rnew_ff;
      rdist_in = rdist_ff;  rlong_in = rlong_ff;  rsum_in = rsum_ff;
      t_we = 1'b0;  q_we = 1'b0;  e_we = 1'b0;
      st_waddr = '0;  st_raddr = at[AW-1:0];
      e_waddr = pedge_ff;  e_wdata = ntot_ff;
      nm_raddr = cur_ff;  nm_we = '0;  nm_waddr = ntot_ff;
      nm_wlen = NW'(nlen);  nm_wlink = '0;  nm_wcnt = CW'(1);
      judge = 1'b0;  hit = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            e_we    = 1'b1;
            e_waddr = clr_ff;
            e_wdata = '0;
            clr_in  = clr_ff + EAW'(1);
            if (clr_ff == EAW'(EDEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               sym_in   = req_symbol;
               new_in   = 1'b0;
               stat_in  = ptb_pkg::ST_OK;
               state_in = S_DONE;
               case (req_command)
                  ptb_pkg::CMD_APPEND: begin
                     if (fin_ff || req_bad) begin
                        stat_in = ptb_pkg::ST_ORDER;
                     end else if (int'(tlen_ff) >= MAX_LEN) begin
                        stat_in = ptb_pkg::ST_FULL;
                     end else begin
                        t_we     = 1'b1;
                        st_waddr = tlen_ff[AW-1:0];
                        cur_in   = last_ff;
                        mode_in  = M_W1;
                        state_in = S_NRD;
                     end
                  end
                  ptb_pkg::CMD_FINALIZE: begin
                     if (fin_ff) begin
                        stat_in = ptb_pkg::ST_ORDER;
                     end else begin
                        fpass_in = 1'b0;
                        fi_in    = ntot_ff - NW'(1);
                        state_in = S_FRD;
                     end
                  end
                  ptb_pkg::CMD_QUERY: begin
                     if (!fin_ff) begin
                        stat_in = ptb_pkg::ST_ORDER;
                     end else if (!req_restart && int'(qlen_ff) >= MAX_LEN) begin
                        stat_in = ptb_pkg::ST_FULL;
                     end else begin
                        q_we     = 1'b1;
                        st_waddr = req_restart ? '0 : qlen_ff[AW-1:0];
                        mode_in  = M_Q;
                        if (req_restart) begin
                           qlen_in = '0;
                           qsum_in = '0;
                           qnode_in = '0;
                        end
                        if (req_restart || qnode_ff == '0) begin
                           cur_in   = '0;
                           eaddr_in = req_bad ? '0 : EAW'(req_symbol);
                           state_in = S_ERD;
                        end else begin
                           cur_in   = qnode_ff;
                           state_in = S_NRD;
                        end
                     end
                  end
                  default: begin
                     stat_in = ptb_pkg::ST_ORDER;
                  end
               endcase
            end
         end
         S_NRD: begin
            nm_raddr = cur_ff;
            state_in = S_NLEN;
         end
         S_NLEN: begin
            len_in  = nm_len;
            link_in = nm_link;
            if (nm_len < 0) begin
               judge = 1'b1;
               hit   = 1'b1;
            end else if (at < 0) begin
               judge = 1'b1;
            end else begin
               state_in = S_TCMP;
            end
         end
         S_TCMP: begin
            judge = 1'b1;
            hit   = (st_data == sym_ff);
         end
         S_ERD: begin
            state_in = S_EDAT;
         end
         S_EDAT: begin
            case (mode_ff)
               M_W1: begin
                  if (e_val != '0) begin
                     last_in  = e_val;
                     tgt_in   = e_val;
                     state_in = S_CRD;
                  end else begin
                     cur_in   = link_ff;
                     mode_in  = M_W2;
                     state_in = S_NRD;
                  end
               end
               M_W2: begin
                  e_we     = 1'b1;
                  nm_we    = '{len: 1'b1, link: 1'b1, cnt: 1'b1};
                  nm_wlink = (e_val == '0) ? NW'(1) : e_val;
                  ntot_in  = ntot_ff + NW'(1);
                  last_in  = ntot_ff;
                  if (NW'(nlen) > long_ff) begin
                     long_in = NW'(nlen);
                  end
                  new_in   = 1'b1;
                  tlen_in  = tlen_ff + NW'(1);
                  state_in = S_DONE;
               end
               default: begin
                  if (cur_ff == '0 || e_val != '0) begin
                     if (e_val != '0) begin
                        tgt_in   = e_val;
                        state_in = S_CRD;
                     end else begin
                        qnode_in = '0;
                        qlen_in  = qlen_ff + NW'(1);
                        state_in = S_DONE;
                     end
                  end else if (link_ff == '0) begin
                     cur_in   = '0;
                     eaddr_in = ea_root;
                     state_in = S_ERD;
                  end else begin
                     cur_in   = link_ff;
                     state_in = S_NRD;
                  end
               end
            endcase
         end
         S_CRD: begin
            nm_raddr = tgt_ff;
            state_in = S_CUPD;
         end
         S_CUPD: begin
            if (mode_ff == M_Q) begin
               qsum_in  = ptb_pkg::sat_add48(qsum_ff, nm_cnt);
               qnode_in = tgt_ff;
               qlen_in  = qlen_ff + NW'(1);
            end else begin
               nm_we    = '{len: 1'b0, link: 1'b0, cnt: 1'b1};
               nm_waddr = tgt_ff;
               nm_wcnt  = ptb_pkg::sat_add32(nm_cnt, CW'(1));
               tlen_in  = tlen_ff + NW'(1);
            end
            state_in = S_DONE;
         end
         S_FRD: begin
            nm_raddr = fi_ff;
            if (!fpass_ff && fi_ff < NW'(2)) begin
               fpass_in = 1'b1;
               fi_in    = NW'(2);
            end else if (fpass_ff && fi_ff >= ntot_ff) begin
               fin_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_FA;
            end
         end
         S_FA: begin
            fcnt_in  = nm_cnt;
            flink_in = nm_link;
            nm_raddr = nm_link;
            if (nm_link >= NW'(2)) begin
               state_in = S_FB;
            end else begin
               fi_in    = fpass_ff ? fi_ff + NW'(1) : fi_ff - NW'(1);
               state_in = S_FRD;
            end
         end
         S_FB: begin
            nm_we    = '{len: 1'b0, link: 1'b0, cnt: 1'b1};
            nm_waddr = fpass_ff ? fi_ff : flink_ff;
            nm_wcnt  = ptb_pkg::sat_add32(nm_cnt, fcnt_ff);
            fi_in    = fpass_ff ? fi_ff + NW'(1) : fi_ff - NW'(1);
            state_in = S_FRD;
         end
         S_DONE: begin
            if (!rv_ff || rsp_ready) begin
               rv_in    = 1'b1;
               rstat_in = stat_ff;
               rnode_in = (cmd_ff == ptb_pkg::CMD_QUERY) ? qnode_ff : last_ff;
               rnew_in  = new_ff;
               rdist_in = ntot_ff - NW'(2);
               rlong_in = long_ff;
               rsum_in  = qsum_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (judge) begin
         if (hit) begin
            eaddr_in = ea_cur;
            state_in = S_ERD;
            if (mode_ff == M_W1) begin
               pedge_in = ea_cur;
               plen_in  = len_cur;
            end
         end else if (mode_ff == M_Q && link_cur == '0) begin
            cur_in   = '0;
            eaddr_in = ea_root;
            state_in = S_ERD;
         end else begin
            cur_in   = link_cur;
            state_in = S_NRD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         last_ff  <= '0;
         ntot_ff  <= NW'(2);
         tlen_ff  <= '0;
         long_ff  <= '0;
         qnode_ff <= '0;
         qlen_ff  <= '0;
         qsum_ff  <= '0;
         fin_ff   <= 1'b0;
         rv_ff    <= 1'b0;
         mode_ff  <= M_W1;
         fpass_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         last_ff  <= last_in;
         ntot_ff  <= ntot_in;
         tlen_ff  <= tlen_in;
         long_ff  <= long_in;
         qnode_ff <= qnode_in;
         qlen_ff  <= qlen_in;
         qsum_ff  <= qsum_in;
         fin_ff   <= fin_in;
         rv_ff    <= rv_in;
         mode_ff  <= mode_in;
         fpass_ff <= fpass_in;
      end
      cmd_ff   <= cmd_in;
      sym_ff   <= sym_in;
      stat_ff  <= stat_in;
      new_ff   <= new_in;
      cur_ff   <= cur_in;
      link_ff  <= link_in;
      len_ff   <= len_in;
      plen_ff  <= plen_in;
      pedge_ff <= pedge_in;
      eaddr_ff <= eaddr_in;
      tgt_ff   <= tgt_in;
      fi_ff    <= fi_in;
      fcnt_ff  <= fcnt_in;
      flink_ff <= flink_in;
      rstat_ff <= rstat_in;
      rnode_ff <= rnode_in;
      rnew_ff  <= rnew_in;
      rdist_ff <= rdist_in;
      rlong_ff <= rlong_in;
      rsum_ff  <= rsum_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_status         = rstat_ff;
   assign rsp_node           = rnode_ff;
   assign rsp_is_new         = rnew_ff;
   assign rsp_distinct_count = rdist_ff;
   assign rsp_longest        = rlong_ff;
   assign rsp_query_sum      = rsum_ff;

   a_longest_fits: assert property (@(posedge clock) disable iff (reset)
      long_ff <= tlen_ff)
      else $error("longest palindrome exceeds text length");

   a_nodes_bounded: assert property (@(posedge clock) disable iff (reset)
      ntot_ff <= tlen_ff + NW'(2))
      else $error("more nodes than appended symbols");

   a_finalize_sticks: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> fin_ff)
      else $error("finalized flag dropped");

   a_no_beat_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready)
      else $error("req beat taken during edge clear");

endmodule
`default_nettype wire

[rtl/ptb_node_mem.sv]
// Node store: length, suffix link and occurrence count per node, one read port.
// Roots read as fixed values (node 0 length -1, node 1 length 0, links 0, counts 1).
// Depends on ptb_pkg.
`default_nettype none
module ptb_node_mem #(
   parameter int NODES = ptb_pkg::MAX_LEN_DEF + 2,
   parameter int NW    = $clog2(ptb_pkg::MAX_LEN_DEF + 2)
) (
   input  wire logic                        clock,
   input  wire logic [NW-1:0]               rd_addr,
   output logic signed [NW:0]               rd_len,
   output logic [NW-1:0]                    rd_link,
   output logic [ptb_pkg::CNT_W-1:0]        rd_cnt,
   input  wire ptb_pkg::node_wr_type        wr_en,
   input  wire logic [NW-1:0]               wr_addr,
   input  wire logic [NW-1:0]               wr_len,
   input  wire logic [NW-1:0]               wr_link,
   input  wire logic [ptb_pkg::CNT_W-1:0]   wr_cnt
);

   logic [NW-1:0]             len_mem  [NODES];
   logic [NW-1:0]             link_mem [NODES];
   logic [ptb_pkg::CNT_W-1:0] cnt_mem  [NODES];

   logic [NW-1:0]             len_ff;
   logic [NW-1:0]             link_ff;
   logic [ptb_pkg::CNT_W-1:0] cnt_ff;
   logic                      root0_ff;
   logic                      root1_ff;

   always_ff @(posedge clock) begin
      if (wr_en.len) begin
         len_mem[wr_addr] <= wr_len;
      end
      if (wr_en.link) begin
         link_mem[wr_addr] <= wr_link;
      end
      if (wr_en.cnt) begin
         cnt_mem[wr_addr] <= wr_cnt;
      end
      len_ff   <= len_mem[rd_addr];
      link_ff  <= link_mem[rd_addr];
      cnt_ff   <= cnt_mem[rd_addr];
      root0_ff <= (rd_addr == NW'(0));
      root1_ff <= (rd_addr == NW'(1));
   end

   always_comb begin
      if (root0_ff) begin
         rd_len  = '1;
         rd_link = '0;
         rd_cnt  = ptb_pkg::CNT_W'(1);
      end else if (root1_ff) begin
         rd_len  = '0;
         rd_link = '0;
         rd_cnt  = ptb_pkg::CNT_W'(1);
      end else begin
         rd_len  = $signed({1'b0, len_ff});
         rd_link = link_ff;
         rd_cnt  = cnt_ff;
      end
   end

endmodule
`default_nettype wire
